### src/lavm_pkg.sv
package lavm_pkg;

    // Field widths of the ports.
    localparam int DATA_W  = 32;
    localparam int ROW_W   = 2;
    localparam int CFG_W   = 3;

    // Q2.30 fraction bits and the unit value.
    localparam int Q_FRAC  = 30;
    localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;

    // Normalizer datapath widths, all fixed by the Q2.30 prescale range.
    localparam int PRE_MSB  = 29;               // prescaled maximum lies in [2^29, 2^30)
    localparam int SHL_W    = 5;                // left shift amount, at most PRE_MSB
    localparam int SC_W     = PRE_MSB + 1;      // prescaled component
    localparam int SQ_W     = 2 * SC_W;         // square of a component
    localparam int SUM_W    = SQ_W + 2;         // sum of three squares
    localparam int LEN_W    = SUM_W / 2;        // square root of the sum
    localparam int RES_W    = SUM_W + 1;        // root recurrence working width
    localparam int SQ_STEPS = LEN_W;            // one root bit per stage
    localparam int NUM_W    = SC_W + LEN_W;     // dividend (component << 30) + len/2
    localparam int DIV_W    = NUM_W + 1;        // shifted divisor compare width
    localparam int Q_W      = LEN_W;            // quotient bits
    localparam int DV_STEPS = Q_W;              // one quotient bit per stage

    // Widths of the vectors that get normalized.
    localparam int DIFF_W  = DATA_W + 1;        // target - eye, exact
    localparam int PROD_W  = 2 * DATA_W;        // 32x32 product
    localparam int CR_W    = PROD_W;            // cross product component

    // Configuration register indexes.
    typedef logic [CFG_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TARGET_X = 3'd0;
    localparam cfg_idx_t REG_TARGET_Y = 3'd1;
    localparam cfg_idx_t REG_TARGET_Z = 3'd2;
    localparam cfg_idx_t REG_UP_X     = 3'd3;
    localparam cfg_idx_t REG_UP_Y     = 3'd4;
    localparam cfg_idx_t REG_UP_Z     = 3'd5;

    localparam logic signed [DATA_W-1:0] UP_Y_RESET = 32'sh0001_0000;

    // Matrix row codes.
    typedef logic [ROW_W-1:0] row_idx_t;
    localparam row_idx_t ROW_RIGHT = 2'd0;
    localparam row_idx_t ROW_UP    = 2'd1;
    localparam row_idx_t ROW_FWD   = 2'd2;

    // One input request: the camera eye position.
    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
    } eye_t;

    // One result request: a matrix row.
    typedef struct packed {
        row_idx_t                 row_index;
        logic signed [DATA_W-1:0] axis_x;
        logic signed [DATA_W-1:0] axis_y;
        logic signed [DATA_W-1:0] axis_z;
        logic signed [DATA_W-1:0] translation;
        logic                     degenerate;
        logic                     last_row;
    } row_t;

    // Side data that rides through the second normalizer.
    typedef struct packed {
        eye_t                   eye;
        logic [2:0][DATA_W-1:0] fwd;
        logic                   ok;
    } tagb_t;

    localparam int NRM_A_IW = DIFF_W;
    localparam int NRM_A_PW = $bits(eye_t);
    localparam int NRM_B_IW = CR_W;
    localparam int NRM_B_PW = $bits(tagb_t);

endpackage

### src/look_at_view_matrix.sv
// Channel   Direction  Handshake             Content
// eye       in         eye_valid/eye_stall   camera eye position (eye_t)
// row       out        row_valid/row_stall   one matrix row (row_t), three per request
// cfg       in         cfg_valid/cfg_ready   register index and 32-bit write data
//
// A request yields three rows, right, up and forward, one per cycle on the row port while
// row_stall is low, so the single row port sets the rate at which requests are sustained.
// The delay from an accepted request to its first row is dominated by two pipelined
// normalizers of 69 stages each (31-stage square root, 31-stage divider).
// Reset clears all valid bits and sets target to zero and up to (0, 2^16, 0).
// The pipeline freezes only while its last stage holds a request the row buffer cannot take.
module look_at_view_matrix
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            eye_valid,
    output logic                            eye_stall,
    input  lavm_pkg::eye_t                  eye,
    output logic                            row_valid,
    input  logic                            row_stall,
    output lavm_pkg::row_t                  row,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  lavm_pkg::cfg_idx_t              cfg_index,
    input  logic [lavm_pkg::DATA_W-1:0]     cfg_data
);
    import lavm_pkg::*;

    // Rounded magnitude of v / 2^30, halves away from zero.
    function automatic logic [DATA_W+1:0] round_mag(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        begin
            m = v[PROD_W-1] ? (~v + PROD_W'(1)) : v;
            m = m + (PROD_W'(1) << (Q_FRAC - 1));
            return (DATA_W+2)'(m >> Q_FRAC);
        end
    endfunction

    logic en;
    logic ser_take;
    logic pl_v_reg;

    // Configuration registers.
    logic signed [DATA_W-1:0] target_reg [3];
    logic signed [DATA_W-1:0] up_reg     [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '{default: '0};
            up_reg     <= '{'0, UP_Y_RESET, '0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_X: target_reg[0] <= cfg_data;
                REG_TARGET_Y: target_reg[1] <= cfg_data;
                REG_TARGET_Z: target_reg[2] <= cfg_data;
                REG_UP_X:     up_reg[0]     <= cfg_data;
                REG_UP_Y:     up_reg[1]     <= cfg_data;
                REG_UP_Z:     up_reg[2]     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Whole pipeline moves unless its last stage is blocked.
    assign en        = !pl_v_reg || ser_take;
    assign eye_stall = !en;

    // Stage P1: exact forward difference target - eye.
    logic signed [DATA_W-1:0] eye_c [3];
    logic                     p1_v_reg;
    eye_t                     p1_eye_reg;
    logic [2:0][DIFF_W-1:0]   p1_d_reg;

    assign eye_c[0] = eye.eye_x;
    assign eye_c[1] = eye.eye_y;
    assign eye_c[2] = eye.eye_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_eye_reg <= eye;
            for (int i = 0; i < 3; i++)
            begin
                p1_d_reg[i] <= DIFF_W'(target_reg[i]) - DIFF_W'(eye_c[i]);
            end
        end
    end

    // Forward axis.
    logic                   na_v;
    logic [2:0][DATA_W-1:0] na_unit;
    logic                   na_ok;
    logic [NRM_A_PW-1:0]    na_side;

    lavm_norm
    #(
        .IW (NRM_A_IW),
        .PW (NRM_A_PW)
    )
    u_norm_fwd
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .vec_valid  (p1_v_reg),
        .vec        (p1_d_reg),
        .side       (p1_eye_reg),
        .unit_valid (na_v),
        .unit       (na_unit),
        .unit_ok    (na_ok),
        .unit_side  (na_side)
    );

    // Stage C1: products of up x forward.
    logic signed [DATA_W-1:0] fa [3];
    logic                     c1_v_reg;
    logic signed [PROD_W-1:0] c1_p_reg [6];
    tagb_t                    c1_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fa[i] = $signed(na_unit[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_p_reg[0] <= up_reg[1] * fa[2];
            c1_p_reg[1] <= up_reg[2] * fa[1];
            c1_p_reg[2] <= up_reg[2] * fa[0];
            c1_p_reg[3] <= up_reg[0] * fa[2];
            c1_p_reg[4] <= up_reg[0] * fa[1];
            c1_p_reg[5] <= up_reg[1] * fa[0];
            c1_tag_reg  <= '{eye: eye_t'(na_side), fwd: na_unit, ok: na_ok};
        end
    end

    // Stage C2: cross product differences.
    logic                 c2_v_reg;
    logic [2:0][CR_W-1:0] c2_cr_reg;
    tagb_t                c2_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_cr_reg[0] <= c1_p_reg[0] - c1_p_reg[1];
            c2_cr_reg[1] <= c1_p_reg[2] - c1_p_reg[3];
            c2_cr_reg[2] <= c1_p_reg[4] - c1_p_reg[5];
            c2_tag_reg   <= c1_tag_reg;
        end
    end

    // Right axis.
    logic                   nb_v;
    logic [2:0][DATA_W-1:0] nb_unit;
    logic                   nb_ok;
    logic [NRM_B_PW-1:0]    nb_side;
    tagb_t                  nb_tag;

    lavm_norm
    #(
        .IW (NRM_B_IW),
        .PW (NRM_B_PW)
    )
    u_norm_right
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .vec_valid  (c2_v_reg),
        .vec        (c2_cr_reg),
        .side       (c2_tag_reg),
        .unit_valid (nb_v),
        .unit       (nb_unit),
        .unit_ok    (nb_ok),
        .unit_side  (nb_side)
    );

    assign nb_tag = tagb_t'(nb_side);

    // Stage U1: products of forward x right.
    logic signed [DATA_W-1:0] fb [3];
    logic signed [DATA_W-1:0] rb [3];
    logic                     u1_v_reg;
    logic signed [PROD_W-1:0] u1_p_reg   [6];
    logic signed [DATA_W-1:0] u1_fwd_reg [3];
    logic signed [DATA_W-1:0] u1_rgt_reg [3];
    eye_t                     u1_eye_reg;
    logic                     u1_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fb[i] = $signed(nb_tag.fwd[i]);
            rb[i] = $signed(nb_unit[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_p_reg[0] <= fb[1] * rb[2];
            u1_p_reg[1] <= fb[2] * rb[1];
            u1_p_reg[2] <= fb[2] * rb[0];
            u1_p_reg[3] <= fb[0] * rb[2];
            u1_p_reg[4] <= fb[0] * rb[1];
            u1_p_reg[5] <= fb[1] * rb[0];
            u1_fwd_reg  <= fb;
            u1_rgt_reg  <= rb;
            u1_eye_reg  <= nb_tag.eye;
            u1_ok_reg   <= nb_tag.ok && nb_ok;
        end
    end

    // Stage U2: up axis rounded and clamped; all axes cleared when degenerate.
    logic signed [PROD_W-1:0] udiff [3];
    logic [DATA_W+1:0]        umag  [3];
    logic [DATA_W-1:0]        uclp  [3];
    logic signed [DATA_W-1:0] upv   [3];
    logic signed [DATA_W-1:0] ax_next [3][3];
    logic                     u2_v_reg;
    logic signed [DATA_W-1:0] u2_ax_reg [3][3];
    logic signed [DATA_W-1:0] u2_eye_reg [3];
    logic                     u2_ok_reg;

    always_comb
    begin
        udiff[0] = u1_p_reg[0] - u1_p_reg[1];
        udiff[1] = u1_p_reg[2] - u1_p_reg[3];
        udiff[2] = u1_p_reg[4] - u1_p_reg[5];
        for (int i = 0; i < 3; i++)
        begin
            umag[i] = round_mag(udiff[i]);
            uclp[i] = (umag[i] > (DATA_W+2)'(ONE_Q30)) ? ONE_Q30 : umag[i][DATA_W-1:0];
            upv[i]  = udiff[i][PROD_W-1] ? $signed(~uclp[i] + DATA_W'(1)) : $signed(uclp[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            ax_next[0][i] = u1_ok_reg ? u1_rgt_reg[i] : '0;
            ax_next[1][i] = u1_ok_reg ? upv[i]        : '0;
            ax_next[2][i] = u1_ok_reg ? u1_fwd_reg[i] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_ax_reg     <= ax_next;
            u2_eye_reg[0] <= u1_eye_reg.eye_x;
            u2_eye_reg[1] <= u1_eye_reg.eye_y;
            u2_eye_reg[2] <= u1_eye_reg.eye_z;
            u2_ok_reg     <= u1_ok_reg;
        end
    end

    // Stage T1: axis times eye products.
    logic                     t1_v_reg;
    logic signed [PROD_W-1:0] t1_p_reg  [3][3];
    logic signed [DATA_W-1:0] t1_ax_reg [3][3];
    logic                     t1_ok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    t1_p_reg[r][c] <= u2_ax_reg[r][c] * u2_eye_reg[c];
                end
            end
            t1_ax_reg <= u2_ax_reg;
            t1_ok_reg <= u2_ok_reg;
        end
    end

    // Stage T2: dot products.
    logic                     t2_v_reg;
    logic signed [PROD_W-1:0] t2_dot_reg [3];
    logic signed [DATA_W-1:0] t2_ax_reg  [3][3];
    logic                     t2_ok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                t2_dot_reg[r] <= t1_p_reg[r][0] + t1_p_reg[r][1] + t1_p_reg[r][2];
            end
            t2_ax_reg <= t1_ax_reg;
            t2_ok_reg <= t1_ok_reg;
        end
    end

    // Stage T3: negated, rounded and saturated translation; rows assembled.
    localparam logic [DATA_W+1:0] MAG_MAX_POS = (DATA_W+2)'(32'h7FFF_FFFF);
    localparam logic [DATA_W+1:0] MAG_MAX_NEG = (DATA_W+2)'(32'h8000_0000);
    localparam logic [DATA_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG     = 32'h8000_0000;

    logic [DATA_W+1:0] tmag [3];
    logic [DATA_W-1:0] trn  [3];
    row_t              rows_next [3];
    row_t              pl_rows_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tmag[r] = round_mag(t2_dot_reg[r]);
            if (t2_dot_reg[r][PROD_W-1])
            begin
                trn[r] = (tmag[r] > MAG_MAX_POS) ? SAT_POS : tmag[r][DATA_W-1:0];
            end
            else if (tmag[r] > MAG_MAX_NEG)
            begin
                trn[r] = SAT_NEG;
            end
            else
            begin
                trn[r] = ~tmag[r][DATA_W-1:0] + DATA_W'(1);
            end
            rows_next[r].row_index   = row_idx_t'(r);
            rows_next[r].axis_x      = t2_ax_reg[r][0];
            rows_next[r].axis_y      = t2_ax_reg[r][1];
            rows_next[r].axis_z      = t2_ax_reg[r][2];
            rows_next[r].translation = trn[r];
            rows_next[r].degenerate  = !t2_ok_reg;
            rows_next[r].last_row    = (row_idx_t'(r) == ROW_FWD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_rows_reg <= rows_next;
        end
    end

    // Valid bits of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            u1_v_reg <= 1'b0;
            u2_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            pl_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= eye_valid;
            c1_v_reg <= na_v;
            c2_v_reg <= c1_v_reg;
            u1_v_reg <= nb_v;
            u2_v_reg <= u1_v_reg;
            t1_v_reg <= u2_v_reg;
            t2_v_reg <= t1_v_reg;
            pl_v_reg <= t2_v_reg;
        end
    end

    // Row buffer: holds one request's three rows and shifts them out.
    logic ser_v_reg;
    row_t ser_rows_reg [3];

    assign ser_take = !ser_v_reg || (ser_rows_reg[0].last_row && !row_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_v_reg <= 1'b0;
        end
        else if (ser_take)
        begin
            ser_v_reg <= pl_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            ser_rows_reg <= pl_rows_reg;
        end
        else if (!row_stall)
        begin
            ser_rows_reg[0] <= ser_rows_reg[1];
            ser_rows_reg[1] <= ser_rows_reg[2];
        end
    end

    assign row_valid = ser_v_reg;
    assign row       = ser_rows_reg[0];

    // A degenerate row carries nothing but the flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.degenerate |->
            row.axis_x == '0 && row.axis_y == '0 && row.axis_z == '0 && row.translation == '0)
        else $error("degenerate row with nonzero fields");

    // Only the forward row closes a matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row.last_row == (row.row_index == ROW_FWD)))
        else $error("last_row flag does not match row index");

    // Input is held off only when the last stage is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        eye_stall |-> pl_v_reg && ser_v_reg)
        else $error("input stalled with room in the pipeline");

    // After the final row leaves with nothing behind it, the port goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row.last_row && !pl_v_reg |=> !row_valid)
        else $error("row port stayed busy after the final row");

endmodule

### src/lavm_norm.sv
module lavm_norm
#(
    parameter int IW = lavm_pkg::NRM_A_IW,
    parameter int PW = lavm_pkg::NRM_A_PW
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vec_valid,
    input  logic [2:0][IW-1:0]                 vec,
    input  logic [PW-1:0]                      side,
    output logic                               unit_valid,
    output logic [2:0][lavm_pkg::DATA_W-1:0]   unit,
    output logic                               unit_ok,
    output logic [PW-1:0]                      unit_side
);
    import lavm_pkg::*;

    localparam int PBW = $clog2(IW);

    typedef struct packed {
        logic [PW-1:0] side;
        logic [2:0]    neg;
        logic          zero;
    } ntag_t;

    // Stage 1: magnitudes and their maximum.
    logic [IW-1:0] mag [3];
    logic [IW-1:0] mx;
    logic [2:0]    neg;
    logic          s1_v_reg;
    logic [IW-1:0] s1_mag_reg [3];
    logic [IW-1:0] s1_max_reg;
    ntag_t         s1_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = vec[i][IW-1];
            mag[i] = neg[i] ? (~vec[i] + IW'(1)) : vec[i];
        end
        mx = mag[0];
        if (mag[1] > mx)
        begin
            mx = mag[1];
        end
        if (mag[2] > mx)
        begin
            mx = mag[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg <= mag;
            s1_max_reg <= mx;
            s1_tag_reg <= '{side: side, neg: neg, zero: 1'b0};
        end
    end

    // Stage 2: leading one of the maximum gives the prescale shift.
    logic [PBW-1:0]   pos;
    logic [PBW-1:0]   shr_next;
    logic [SHL_W-1:0] shl_next;
    logic             s2_v_reg;
    logic [IW-1:0]    s2_mag_reg [3];
    logic [PBW-1:0]   s2_shr_reg;
    logic [SHL_W-1:0] s2_shl_reg;
    ntag_t            s2_tag_reg;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (s1_max_reg[i])
            begin
                pos = PBW'(i);
            end
        end
        shr_next = (pos > PBW'(PRE_MSB)) ? pos - PBW'(PRE_MSB) : '0;
        shl_next = (pos < PBW'(PRE_MSB)) ? SHL_W'(PRE_MSB - int'(pos)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mag_reg <= s1_mag_reg;
            s2_shr_reg <= shr_next;
            s2_shl_reg <= shl_next;
            s2_tag_reg <= '{side: s1_tag_reg.side, neg: s1_tag_reg.neg,
                            zero: (s1_max_reg == '0)};
        end
    end

    // Stage 3: prescale every component into the 30-bit range.
    logic [IW-1:0]   shifted [3];
    logic [SC_W-1:0] sc_next [3];
    logic            s3_v_reg;
    logic [SC_W-1:0] s3_sc_reg [3];
    ntag_t           s3_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = s2_mag_reg[i] >> s2_shr_reg;
            sc_next[i] = shifted[i][SC_W-1:0] << s2_shl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sc_reg  <= sc_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Stage 4: squares.
    logic            s4_v_reg;
    logic [SQ_W-1:0] s4_sq_reg [3];
    logic [SC_W-1:0] s4_sc_reg [3];
    ntag_t           s4_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= SQ_W'(s3_sc_reg[i]) * SQ_W'(s3_sc_reg[i]);
            end
            s4_sc_reg  <= s3_sc_reg;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    // Stage 5: sum of squares.
    logic             s5_v_reg;
    logic [SUM_W-1:0] s5_sum_reg;
    logic [SC_W-1:0]  s5_sc_reg [3];
    ntag_t            s5_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_sum_reg <= SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
            s5_sc_reg  <= s4_sc_reg;
            s5_tag_reg <= s4_tag_reg;
        end
    end

    // Square root: one result bit per stage, floor of the root.
    logic             sq_v_reg   [SQ_STEPS];
    logic [SUM_W-1:0] sq_n_reg   [SQ_STEPS];
    logic [RES_W-1:0] sq_res_reg [SQ_STEPS];
    logic [SC_W-1:0]  sq_sc_reg  [SQ_STEPS][3];
    ntag_t            sq_tag_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic             vi;
        logic [SUM_W-1:0] ni;
        logic [RES_W-1:0] ri;
        logic [SC_W-1:0]  sci [3];
        ntag_t            ti;
        logic [RES_W-1:0] trial;
        logic             take;
        logic [SUM_W-1:0] n_next;
        logic [RES_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign vi  = s5_v_reg;
            assign ni  = s5_sum_reg;
            assign ri  = '0;
            assign sci = s5_sc_reg;
            assign ti  = s5_tag_reg;
        end
        else
        begin : g_rest
            assign vi  = sq_v_reg[k-1];
            assign ni  = sq_n_reg[k-1];
            assign ri  = sq_res_reg[k-1];
            assign sci = sq_sc_reg[k-1];
            assign ti  = sq_tag_reg[k-1];
        end

        always_comb
        begin
            trial    = ri + BIT;
            take     = RES_W'(ni) >= trial;
            n_next   = take ? SUM_W'(RES_W'(ni) - trial) : ni;
            res_next = take ? (ri >> 1) + BIT : (ri >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[k]   <= n_next;
                sq_res_reg[k] <= res_next;
                sq_sc_reg[k]  <= sci;
                sq_tag_reg[k] <= ti;
            end
        end
    end

    // Divider setup: dividend is the component in Q30 plus half the length.
    logic [LEN_W-1:0] len;
    logic             d0_v_reg;
    logic [NUM_W-1:0] d0_num_reg [3];
    logic [LEN_W-1:0] d0_len_reg;
    ntag_t            d0_tag_reg;

    assign len = sq_res_reg[SQ_STEPS-1][LEN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d0_num_reg[i] <= (NUM_W'(sq_sc_reg[SQ_STEPS-1][i]) << Q_FRAC)
                               + NUM_W'(len >> 1);
            end
            d0_len_reg <= len;
            d0_tag_reg <= sq_tag_reg[SQ_STEPS-1];
        end
    end

    // Restoring division, three lanes, one quotient bit per stage.
    logic             dv_v_reg   [DV_STEPS];
    logic [NUM_W-1:0] dv_rem_reg [DV_STEPS][3];
    logic [Q_W-1:0]   dv_q_reg   [DV_STEPS][3];
    logic [LEN_W-1:0] dv_len_reg [DV_STEPS];
    ntag_t            dv_tag_reg [DV_STEPS];

    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_dv
        localparam int SH = DV_STEPS - 1 - j;
        logic             vi;
        logic [NUM_W-1:0] remi [3];
        logic [Q_W-1:0]   qi   [3];
        logic [LEN_W-1:0] li;
        ntag_t            ti;
        logic [DIV_W-1:0] dsh;
        logic [NUM_W-1:0] rem_next [3];
        logic [Q_W-1:0]   q_next   [3];
        logic             take     [3];

        if (j == 0)
        begin : g_first
            assign vi   = d0_v_reg;
            assign remi = d0_num_reg;
            assign qi   = '{default: '0};
            assign li   = d0_len_reg;
            assign ti   = d0_tag_reg;
        end
        else
        begin : g_rest
            assign vi   = dv_v_reg[j-1];
            assign remi = dv_rem_reg[j-1];
            assign qi   = dv_q_reg[j-1];
            assign li   = dv_len_reg[j-1];
            assign ti   = dv_tag_reg[j-1];
        end

        always_comb
        begin
            dsh = DIV_W'(li) << SH;
            for (int i = 0; i < 3; i++)
            begin
                take[i]     = DIV_W'(remi[i]) >= dsh;
                rem_next[i] = take[i] ? NUM_W'(DIV_W'(remi[i]) - dsh) : remi[i];
                q_next[i]   = {qi[i][Q_W-2:0], take[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j] <= rem_next;
                dv_q_reg[j]   <= q_next;
                dv_len_reg[j] <= li;
                dv_tag_reg[j] <= ti;
            end
        end
    end

    // Output stage: restore signs, zero length gives a zero vector.
    ntag_t                  ot;
    logic [DATA_W-1:0]      qx [3];
    logic [2:0][DATA_W-1:0] unit_next;
    logic                   o_v_reg;
    logic [2:0][DATA_W-1:0] o_unit_reg;
    logic                   o_ok_reg;
    logic [PW-1:0]          o_side_reg;

    assign ot = dv_tag_reg[DV_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qx[i] = DATA_W'(dv_q_reg[DV_STEPS-1][i]);
            if (ot.zero)
            begin
                unit_next[i] = '0;
            end
            else
            begin
                unit_next[i] = ot.neg[i] ? (~qx[i] + DATA_W'(1)) : qx[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_unit_reg <= unit_next;
            o_ok_reg   <= !ot.zero;
            o_side_reg <= ot.side;
        end
    end

    // Valid bits of the fixed stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            d0_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= vec_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            d0_v_reg <= sq_v_reg[SQ_STEPS-1];
            o_v_reg  <= dv_v_reg[DV_STEPS-1];
        end
    end

    assign unit_valid = o_v_reg;
    assign unit       = o_unit_reg;
    assign unit_ok    = o_ok_reg;
    assign unit_side  = o_side_reg;

endmodule

### tb/lavm_checker.sv
`timescale 1ns / 1ps

// Watches the eye, row and configuration channels of the look-at block,
// predicts the three view matrix rows of every accepted eye position and
// compares them with the rows that the block delivers.
module lavm_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          eye_valid,
    input  logic                          eye_stall,
    input  lavm_pkg::eye_t                eye,
    input  logic                          row_valid,
    input  logic                          row_stall,
    input  lavm_pkg::row_t                row,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  lavm_pkg::cfg_idx_t            cfg_index,
    input  logic [lavm_pkg::DATA_W-1:0]   cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            rows_seen,
    output int                            degenerate_rows
);
    import lavm_pkg::*;

    typedef longint vec3_t [3];

    // Shadow copy of the configuration registers.
    longint target_pos [3];
    longint up_dir [3];

    // Rows still owed by the block, oldest first.
    row_t owed_rows [$];

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // Divide by 2^s, rounding to nearest with halves away from zero.
    function automatic longint round_down_by(longint v, int s);
        bit [63:0] m;
        m = (magnitude(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] n);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length in Q2.30; returns 0 on zero length.
    function automatic bit unit_vector(input vec3_t v, output vec3_t u);
        bit [63:0] mg [3];
        bit [63:0] m;
        bit [63:0] sum;
        bit [63:0] len;
        bit [63:0] q;
        m = 0;
        sum = 0;
        u = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = magnitude(v[i]);
            if (mg[i] > m)
                m = mg[i];
        end
        if (m == 0)
            return 0;
        while (m >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mg[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mg[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mg[i] * mg[i];
        len = floor_sqrt(sum);
        if (len == 0)
            return 0;
        for (int i = 0; i < 3; i++)
        begin
            q = ((mg[i] << 30) + len / 2) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << Q_FRAC;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    // Build the three rows for one eye position and queue them.
    function automatic void predict_view_rows(eye_t e);
        vec3_t pos, diff, fwd, cr, rgt, upv;
        vec3_t axes [3];
        bit ok;
        longint dot, t;
        row_t r;
        pos[0] = longint'(e.eye_x);
        pos[1] = longint'(e.eye_y);
        pos[2] = longint'(e.eye_z);
        for (int i = 0; i < 3; i++)
            diff[i] = target_pos[i] - pos[i];
        rgt = '{0, 0, 0};
        upv = '{0, 0, 0};
        ok = unit_vector(diff, fwd);
        if (ok)
        begin
            cr[0] = up_dir[1] * fwd[2] - up_dir[2] * fwd[1];
            cr[1] = up_dir[2] * fwd[0] - up_dir[0] * fwd[2];
            cr[2] = up_dir[0] * fwd[1] - up_dir[1] * fwd[0];
            ok = unit_vector(cr, rgt);
        end
        if (ok)
        begin
            upv[0] = clamp_unit(round_down_by(fwd[1] * rgt[2] - fwd[2] * rgt[1], Q_FRAC));
            upv[1] = clamp_unit(round_down_by(fwd[2] * rgt[0] - fwd[0] * rgt[2], Q_FRAC));
            upv[2] = clamp_unit(round_down_by(fwd[0] * rgt[1] - fwd[1] * rgt[0], Q_FRAC));
        end
        else
        begin
            fwd = '{0, 0, 0};
            rgt = '{0, 0, 0};
            upv = '{0, 0, 0};
        end
        axes[ROW_RIGHT] = rgt;
        axes[ROW_UP] = upv;
        axes[ROW_FWD] = fwd;
        for (int k = 0; k < 3; k++)
        begin
            dot = axes[k][0] * pos[0] + axes[k][1] * pos[1] + axes[k][2] * pos[2];
            t = -round_down_by(dot, Q_FRAC);
            if (t > 64'sh7FFF_FFFF)
                t = 64'sh7FFF_FFFF;
            if (t < -64'sh8000_0000)
                t = -64'sh8000_0000;
            r.row_index = row_idx_t'(k);
            r.axis_x = axes[k][0][DATA_W-1:0];
            r.axis_y = axes[k][1][DATA_W-1:0];
            r.axis_z = axes[k][2][DATA_W-1:0];
            r.translation = t[DATA_W-1:0];
            r.degenerate = !ok;
            r.last_row = (row_idx_t'(k) == ROW_FWD);
            owed_rows.push_back(r);
        end
    endfunction

    // Register writes, eye requests and row requests, in that order per edge.
    always @(posedge clk or negedge rst_n)
    begin
        row_t exp_row;
        if (!rst_n)
        begin
            target_pos = '{0, 0, 0};
            up_dir = '{0, longint'(UP_Y_RESET), 0};
            owed_rows.delete();
            errors <= 0;
            pending <= 0;
            rows_seen <= 0;
            degenerate_rows <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_X: target_pos[0] = longint'($signed(cfg_data));
                    REG_TARGET_Y: target_pos[1] = longint'($signed(cfg_data));
                    REG_TARGET_Z: target_pos[2] = longint'($signed(cfg_data));
                    REG_UP_X:     up_dir[0] = longint'($signed(cfg_data));
                    REG_UP_Y:     up_dir[1] = longint'($signed(cfg_data));
                    REG_UP_Z:     up_dir[2] = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (eye_valid && !eye_stall)
                predict_view_rows(eye);
            if (row_valid && !row_stall)
            begin
                rows_seen <= rows_seen + 1;
                if (owed_rows.size() == 0)
                begin
                    $error("row request with no expected row: %p", row);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_row = owed_rows.pop_front();
                    if (exp_row.degenerate)
                        degenerate_rows <= degenerate_rows + 1;
                    if (row != exp_row)
                    begin
                        errors <= errors + 1;
                        if (row.row_index != exp_row.row_index)
                            $error("row_index: expected %0d, got %0d",
                                   exp_row.row_index, row.row_index);
                        if (row.axis_x != exp_row.axis_x)
                            $error("axis_x: expected %0d, got %0d", exp_row.axis_x, row.axis_x);
                        if (row.axis_y != exp_row.axis_y)
                            $error("axis_y: expected %0d, got %0d", exp_row.axis_y, row.axis_y);
                        if (row.axis_z != exp_row.axis_z)
                            $error("axis_z: expected %0d, got %0d", exp_row.axis_z, row.axis_z);
                        if (row.translation != exp_row.translation)
                            $error("translation: expected %0d, got %0d",
                                   exp_row.translation, row.translation);
                        if (row.degenerate != exp_row.degenerate)
                            $error("degenerate: expected %0d, got %0d",
                                   exp_row.degenerate, row.degenerate);
                        if (row.last_row != exp_row.last_row)
                            $error("last_row: expected %0d, got %0d",
                                   exp_row.last_row, row.last_row);
                    end
                end
            end
            pending <= owed_rows.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import lavm_pkg::*;

    localparam int DRAIN_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               eye_valid;
    logic               eye_stall;
    eye_t               eye;
    logic               row_valid;
    logic               row_stall;
    row_t               row;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_idx_t           cfg_index;
    logic [DATA_W-1:0]  cfg_data;

    int errors;
    int pending;
    int rows_seen;
    int degenerate_rows;
    int eyes_sent;
    int settings_used;
    bit no_idle;

    look_at_view_matrix DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .eye_valid(eye_valid),
        .eye_stall(eye_stall),
        .eye(eye),
        .row_valid(row_valid),
        .row_stall(row_stall),
        .row(row),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lavm_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .eye_valid(eye_valid),
        .eye_stall(eye_stall),
        .eye(eye),
        .row_valid(row_valid),
        .row_stall(row_stall),
        .row(row),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending),
        .rows_seen(rows_seen),
        .degenerate_rows(degenerate_rows)
    );

    // Clock with a 4 ns period.
    initial
        clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    // Row receiver: stalls a random number of cycles before each row.
    initial
    begin
        int n;
        row_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                row_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            row_stall <= 1'b0;
            @(posedge clk);
            while (!row_valid)
                @(posedge clk);
        end
    end

    // Write all six registers in one burst.
    task automatic write_view_setup(logic [DATA_W-1:0] tx, logic [DATA_W-1:0] ty,
                                    logic [DATA_W-1:0] tz, logic [DATA_W-1:0] ux,
                                    logic [DATA_W-1:0] uy, logic [DATA_W-1:0] uz);
        logic [DATA_W-1:0] vals [6];
        cfg_idx_t idx [6];
        vals = '{tx, ty, tz, ux, uy, uz};
        idx = '{REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z, REG_UP_X, REG_UP_Y, REG_UP_Z};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Send one eye position after a random gap.
    task automatic send_eye(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            eye_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        eye_valid <= 1'b1;
        eye <= '{x, y, z};
        @(posedge clk);
        while (eye_stall)
            @(posedge clk);
        eyes_sent++;
    endtask

    // Let every expected row arrive, then let the pipeline empty.
    task automatic drain_rows();
        eye_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random eye positions around the current setup.
    task automatic random_eyes(int count, logic [DATA_W-1:0] tx, logic [DATA_W-1:0] ty,
                               logic [DATA_W-1:0] tz, logic [DATA_W-1:0] ux,
                               logic [DATA_W-1:0] uy, logic [DATA_W-1:0] uz);
        int kind;
        int k;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            k = $urandom_range(1, 4);
            if (kind < 5)
                send_eye($urandom, $urandom, $urandom);
            else if (kind < 8)
                send_eye(tx + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                         ty + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                         tz + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            else if (kind == 8)
                send_eye(tx - k * ux, ty - k * uy, tz - k * uz);
            else
                send_eye(tx, ty, tz);
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] r [6];
        rst_n = 1'b0;
        eye_valid = 1'b0;
        eye = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET_X;
        cfg_data = '0;
        no_idle = 1'b0;
        eyes_sent = 0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: plain view, eye on the target, eye along up, extremes.
        send_eye(32'h0000_0000, 32'h0000_0000, 32'hFFFB_0000);
        send_eye(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_eye(32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
        send_eye(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
        send_eye(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eye(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eye(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_eye(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
        send_eye(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        drain_rows();

        // Extreme registers, including the most negative values.
        write_view_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_eye(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_eye(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_eye(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_eye(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_eye(32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE);
        drain_rows();

        // A zero up vector makes every row degenerate.
        write_view_setup(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
        send_eye(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_eye(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        drain_rows();

        // Tiny up vector with a huge forward.
        write_view_setup(0, 0, 32'h7FFF_FFFF, 32'h0000_0001, 0, 32'h0000_0001);
        send_eye(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        send_eye(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        drain_rows();

        // Random setups with random eyes; one phase runs with no idling at all.
        for (int p = 0; p < 5; p++)
        begin
            for (int i = 0; i < 6; i++)
                r[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(0, 32'h000A_0000)
                                                     - 32'h0005_0000;
            write_view_setup(r[0], r[1], r[2], r[3], r[4], r[5]);
            no_idle = (p == 2);
            random_eyes(18, r[0], r[1], r[2], r[3], r[4], r[5]);
            drain_rows();
            no_idle = 1'b0;
        end

        $display("covered %0d eye positions under %0d register setups", eyes_sent,
                 settings_used);
        $display("checked %0d rows, %0d of them degenerate", rows_seen, degenerate_rows);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### look_at_view_matrix.f
src/lavm_pkg.sv
src/lavm_norm.sv
src/look_at_view_matrix.sv
tb/lavm_checker.sv
tb/tb.sv
